>>> design/modular_exponentiation_macros.svh
// Assertion macros shared by the modular exponentiation RTL.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define MEXP_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
		else $error("modexp assertion failed");

// Check a property on every clock edge, reset included.
`define MEXP_ASSERT_ALWAYS(lbl, clk_s, prop) \
	lbl: assert property (@(posedge clk_s) (prop)) \
		else $error("modexp assertion failed");

`else

`define MEXP_ASSERT(lbl, clk_s, rstn_s, prop)
`define MEXP_ASSERT_ALWAYS(lbl, clk_s, prop)

`endif

`endif

>>> design/mexp_pkg.sv
// Package for the modular exponentiation block: default widths and the
// sequencer state type. No dependencies.
package mexp_pkg;

	localparam int unsigned EXP_BITS_DEF = 63;
	localparam int unsigned MOD_BITS_DEF = 31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MUL,
		ST_SQR,
		ST_NEXT
	} state_t;

endpackage

>>> design/modular_exponentiation.sv
// Modular exponentiation top level: square-and-multiply sequencer around a
// shared bit-serial modular multiplier (mexp_mulmod).
// Depends on mexp_pkg and modular_exponentiation_macros.svh.
//
// Usage:
//   Request channel: drive base, exponent and modulus and raise start. The
//   request is taken at a rising edge where start is high and busy is low;
//   busy then stays high until the cycle that carries the result, where it is low.
//   Result channel: power_mod is valid for exactly one cycle while done is
//   high. The receiver cannot stall; it must take the result in that cycle.
//   A modulus of zero is handled as one. Exponent zero returns 1.
// Schedule: every modular multiply runs on one shared bit-serial unit that
//   consumes one multiplier bit per cycle, with a launch and a write-back
//   around the bit steps. One request costs one base reduction, one
//   squaring per exponent bit up to and including the highest set bit,
//   and one multiply per set bit, with a decision state (ST_NEXT) after
//   the reduction and after each squaring. Exponent zero takes only the
//   reduction and one decision. No new request is taken until the
//   previous result is out.
// Reset: arst_n clears the sequencer and the multiplier control at once;
//   the block comes up idle with done low.
`include "modular_exponentiation_macros.svh"

module modular_exponentiation #(
	parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF,
	parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [MOD_BITS-1:0] base,
	input  logic [EXP_BITS-1:0] exponent,
	input  logic [MOD_BITS-1:0] modulus,
	output logic                done,
	output logic [MOD_BITS-1:0] power_mod
);

	mexp_pkg::state_t state_q;
	mexp_pkg::state_t state_d;

	// launch pulses the multiplier on the first cycle of each arithmetic state
	logic                launch_q;
	logic                launch_d;
	logic                done_q;
	logic                done_d;

	logic [EXP_BITS-1:0] exp_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] sq_q;
	logic [MOD_BITS-1:0] mod_q;
	logic [MOD_BITS-1:0] power_mod_q;

	logic                accept;
	logic [MOD_BITS-1:0] mul_a;
	logic [MOD_BITS-1:0] mul_b;
	logic                mul_done;
	logic [MOD_BITS-1:0] mul_p;

	assign accept = start && (state_q == mexp_pkg::ST_IDLE);

	// Operand select for the shared multiplier
	always_comb begin
		case (state_q)
			mexp_pkg::ST_REDUCE: begin
				// base * 1 mod m reduces the base
				mul_a = sq_q;
				mul_b = MOD_BITS'(1);
			end
			mexp_pkg::ST_MUL: begin
				mul_a = acc_q;
				mul_b = sq_q;
			end
			default: begin
				mul_a = sq_q;
				mul_b = sq_q;
			end
		endcase
	end

	mexp_mulmod #(
		.MOD_BITS(MOD_BITS)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (launch_q),
		.a     (mul_a),
		.b     (mul_b),
		.m     (mod_q),
		.done  (mul_done),
		.p     (mul_p)
	);

	// Next state and control
	always_comb begin
		state_d  = state_q;
		launch_d = 1'b0;
		done_d   = 1'b0;
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (start) begin
					state_d  = mexp_pkg::ST_REDUCE;
					launch_d = 1'b1;
				end
			end
			mexp_pkg::ST_REDUCE: begin
				if (mul_done) begin
					state_d = mexp_pkg::ST_NEXT;
				end
			end
			mexp_pkg::ST_MUL: begin
				if (mul_done) begin
					state_d  = mexp_pkg::ST_SQR;
					launch_d = 1'b1;
				end
			end
			mexp_pkg::ST_SQR: begin
				if (mul_done) begin
					state_d = mexp_pkg::ST_NEXT;
				end
			end
			mexp_pkg::ST_NEXT: begin
				// no set bits left: the accumulator is final
				if (exp_q == '0) begin
					state_d = mexp_pkg::ST_IDLE;
					done_d  = 1'b1;
				end else if (exp_q[0]) begin
					state_d  = mexp_pkg::ST_MUL;
					launch_d = 1'b1;
				end else begin
					state_d  = mexp_pkg::ST_SQR;
					launch_d = 1'b1;
				end
			end
			default: begin
				state_d = mexp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mexp_pkg::ST_IDLE;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= launch_d;
			done_q   <= done_d;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			exp_q <= exponent;
			acc_q <= MOD_BITS'(1);
			sq_q  <= base;
			// treat a zero modulus as one
			mod_q <= (modulus == '0) ? MOD_BITS'(1) : modulus;
		end else if (mul_done) begin
			case (state_q)
				mexp_pkg::ST_MUL: begin
					acc_q <= mul_p;
				end
				mexp_pkg::ST_SQR: begin
					sq_q  <= mul_p;
					exp_q <= exp_q >> 1;
				end
				default: begin
					sq_q <= mul_p;
				end
			endcase
		end
		if (done_d) begin
			power_mod_q <= acc_q;
		end
	end

	assign busy      = (state_q != mexp_pkg::ST_IDLE);
	assign done      = done_q;
	assign power_mod = power_mod_q;

	`MEXP_ASSERT(a_accept_busy, clk, arst_n, accept |=> busy)
	`MEXP_ASSERT(a_done_idle, clk, arst_n, done_q |-> (!busy && $past(state_q == mexp_pkg::ST_NEXT)))
	`MEXP_ASSERT(a_result_range, clk, arst_n,
		done_q |-> ((power_mod_q < mod_q) || (power_mod_q == MOD_BITS'(1))))
	`MEXP_ASSERT(a_launch_state, clk, arst_n,
		launch_q |-> ((state_q == mexp_pkg::ST_REDUCE) || (state_q == mexp_pkg::ST_MUL) ||
		(state_q == mexp_pkg::ST_SQR)))
	`MEXP_ASSERT(a_reset_quiet, clk, arst_n, $rose(arst_n) |-> (!done_q && !busy))

endmodule

>>> design/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
// Depends on mexp_pkg and modular_exponentiation_macros.svh.
`include "modular_exponentiation_macros.svh"

module mexp_mulmod #(
	parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MOD_BITS-1:0] a,
	input  logic [MOD_BITS-1:0] b,
	input  logic [MOD_BITS-1:0] m,
	output logic                done,
	output logic [MOD_BITS-1:0] p
);

	localparam int unsigned CNT_W = $clog2(MOD_BITS + 1);

	logic                run_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MOD_BITS-1:0] a_q;
	logic [MOD_BITS-1:0] b_q;
	logic [MOD_BITS-1:0] m_q;
	logic [MOD_BITS-1:0] r_q;

	logic [MOD_BITS:0]   m_w;
	logic [MOD_BITS:0]   dbl;
	logic [MOD_BITS:0]   dbl_red;
	logic [MOD_BITS:0]   sum;
	logic [MOD_BITS:0]   sum_red;

	// r = (2r + a_bit*b) mod m, with r < m and b <= m
	always_comb begin
		m_w     = {1'b0, m_q};
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= m_w) ? (dbl - m_w) : dbl;
		sum     = dbl_red + (a_q[MOD_BITS-1] ? {1'b0, b_q} : '0);
		sum_red = (sum >= m_w) ? (sum - m_w) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(MOD_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			m_q <= m;
			r_q <= '0;
		end else if (run_q) begin
			a_q <= {a_q[MOD_BITS-2:0], 1'b0};
			r_q <= sum_red[MOD_BITS-1:0];
		end
	end

	assign done = done_q;
	assign p    = r_q;

	`MEXP_ASSERT(a_rem_reduced, clk, arst_n, run_q |-> (r_q < m_q))
	`MEXP_ASSERT(a_no_restart, clk, arst_n, start |-> !run_q)
	`MEXP_ASSERT(a_done_after_run, clk, arst_n, done_q |-> ($past(run_q) && !run_q))

endmodule

>>> bench/modular_exponentiation_tb.sv
// Testbench for modular_exponentiation: directed and random requests are
// checked against a square-and-multiply predictor. Depends on mexp_pkg.
`timescale 1ns / 100ps

module modular_exponentiation_tb;

	localparam int unsigned EXP_W = mexp_pkg::EXP_BITS_DEF;
	localparam int unsigned MOD_W = mexp_pkg::MOD_BITS_DEF;

	// Number of random requests after the directed part.
	localparam int unsigned N_RANDOM = 120;
	// The watchdog limit lies well above the whole run, the worst requests
	// and long gaps included, so only a hung run reaches it.
	localparam int unsigned LIMIT_CYCLES = 4_000_000;
	// Watch past the last result for longer than the shortest request
	// takes, to catch a stray done.
	localparam int unsigned TAIL_CYCLES = 100;

	localparam logic [MOD_W-1:0] MOD_MAX = {MOD_W{1'b1}};
	localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};

	typedef struct packed {
		logic [MOD_W-1:0] base;
		logic [EXP_W-1:0] exponent;
		logic [MOD_W-1:0] modulus;
	} mexp_req_t;

	// One pending answer: the request that caused it and the predicted power.
	typedef struct packed {
		mexp_req_t        req;
		logic [MOD_W-1:0] power;
	} power_due_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic [MOD_W-1:0] base = '0;
	logic [EXP_W-1:0] exponent = '0;
	logic [MOD_W-1:0] modulus = '0;
	logic             done;
	logic [MOD_W-1:0] power_mod;

	mexp_req_t   req_backlog[$];
	power_due_t  power_due[$];
	mexp_req_t   live_req;
	int unsigned gap_left = 0;
	int unsigned calm_left = 0;
	int unsigned n_queued = 0;
	int unsigned n_directed = 0;
	int unsigned n_accepted = 0;
	int unsigned n_checked = 0;
	int unsigned n_errors = 0;
	int unsigned n_cycles = 0;

	modular_exponentiation #(
		.EXP_BITS(EXP_W),
		.MOD_BITS(MOD_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.base     (base),
		.exponent (exponent),
		.modulus  (modulus),
		.done     (done),
		.power_mod(power_mod)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Square and multiply, least significant exponent bit first. A zero
	// modulus acts as one; the running product starts at 1 and is only ever
	// reduced as part of a multiply, so exponent zero always gives 1.
	function automatic logic [MOD_W-1:0] square_multiply_power(input mexp_req_t r);
		logic [63:0] md;
		logic [63:0] sq;
		logic [63:0] acc;
		md = (r.modulus == '0) ? 64'd1 : 64'(r.modulus);
		sq = 64'(r.base) % md;
		acc = 64'd1;
		for (int i = 0; i < EXP_W; i++) begin
			if (r.exponent[i])
				acc = (acc * sq) % md;
			sq = (sq * sq) % md;
		end
		return acc[MOD_W-1:0];
	endfunction

	// Idle time before the next request, counted in cycles with busy low.
	// Mostly short, a few long, with runs of back-to-back requests mixed in.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(6, 16);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 4);
		else if (r < 97)
			return $urandom_range(5, 20);
		else
			return $urandom_range(50, 200);
	endfunction

	task automatic queue_req(input logic [MOD_W-1:0] b, input logic [EXP_W-1:0] e,
		input logic [MOD_W-1:0] m);
		mexp_req_t r;
		r.base = b;
		r.exponent = e;
		r.modulus = m;
		req_backlog.insert(req_backlog.size(), r);
		n_queued++;
	endtask

	// Request driver. Hold start and the fields until the request is taken,
	// then wait out a gap before presenting the next one. While no request
	// is offered, put noise on the fields so that only the values present at
	// the accepting edge may matter.
	always @(posedge clk or negedge arst_n) begin
		logic take;
		logic nxt_start;
		power_due_t due;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			take = start && !busy;
			nxt_start = start && !take;
			if (take) begin
				// Predict at acceptance; results come back in request order.
				due.req = live_req;
				due.power = square_multiply_power(live_req);
				power_due.insert(power_due.size(), due);
				n_accepted++;
				gap_left = pick_gap();
			end
			if (!nxt_start) begin
				if (gap_left > 0) begin
					// Count the gap only while the block is idle, so it lands
					// on the idle phase rather than vanishing under busy.
					if (!busy)
						gap_left--;
				end else if (req_backlog.size() > 0) begin
					live_req = req_backlog.pop_front();
					nxt_start = 1'b1;
				end
			end
			start <= nxt_start;
			if (nxt_start) begin
				base <= live_req.base;
				exponent <= live_req.exponent;
				modulus <= live_req.modulus;
			end else begin
				base <= MOD_W'($urandom);
				exponent <= EXP_W'({$urandom, $urandom});
				modulus <= MOD_W'($urandom);
			end
		end
	end

	// Result monitor: done marks a one-cycle result; compare it with the
	// oldest pending prediction.
	always @(posedge clk) begin
		power_due_t pw;
		if (arst_n && done) begin
			if (power_due.size() == 0) begin
				$display("%0t: power_mod %0d with no request outstanding", $time, power_mod);
				n_errors++;
			end else begin
				pw = power_due.pop_front();
				n_checked++;
				if (power_mod !== pw.power) begin
					$display("%0t: power_mod expected %0d, actual %0d (base %0d exp %0d mod %0d)",
						$time, pw.power, power_mod, pw.req.base, pw.req.exponent,
						pw.req.modulus);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: drop the run if it never drains.
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d of %0d requests taken, %0d results pending",
				$time, n_accepted, n_queued, power_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [63:0] span;
		logic [EXP_W-1:0] e;
		int unsigned top;
		int unsigned kind;

		// Directed part: field extremes and the corner cases.
		queue_req('0, '0, MOD_W'(1));                  // exponent zero, modulus one
		queue_req(MOD_MAX, '0, MOD_MAX);               // exponent zero, widest operands
		queue_req(MOD_W'(9), '0, '0);                  // zero modulus, exponent zero
		queue_req(MOD_W'(5), EXP_W'(3), '0);           // zero modulus, nonzero exponent
		queue_req(MOD_MAX, EXP_MAX, '0);               // zero modulus, widest others
		queue_req(MOD_MAX, EXP_MAX, MOD_W'(1));        // modulus one
		queue_req('0, EXP_W'(5), MOD_W'(7));           // zero base
		queue_req('0, '0, MOD_W'(7));                  // zero base to the zero
		queue_req(MOD_MAX, EXP_MAX, MOD_MAX);          // base equal to modulus
		queue_req(MOD_MAX, EXP_MAX, MOD_MAX - 1'b1);   // base one above modulus
		queue_req(MOD_W'(1000), EXP_W'(1), MOD_W'(7)); // base reduced first
		queue_req(MOD_W'(12345), EXP_W'(1), MOD_MAX);  // single low bit
		queue_req(MOD_W'(3), EXP_W'(1) << (EXP_W - 1), MOD_MAX); // top bit only
		queue_req(MOD_W'(2), EXP_MAX, MOD_W'(1000003)); // every bit set
		queue_req(MOD_MAX - 1'b1, EXP_W'(2), MOD_MAX);  // (m-1)^2
		queue_req(MOD_MAX, EXP_MAX, MOD_W'(2));
		queue_req(MOD_W'(1), EXP_MAX, MOD_MAX);
		queue_req(MOD_MAX, EXP_W'({(EXP_W + 1) / 2{2'b01}}), MOD_MAX - MOD_W'(2));
		queue_req(MOD_W'(7), EXP_W'({(EXP_W + 1) / 2{2'b10}}), MOD_W'(65521));
		queue_req(MOD_W'(46341), EXP_W'(2), MOD_MAX);   // product just above 2^31
		n_directed = n_queued;

		// Random part: mostly full-width operands, with short exponents,
		// small moduli and exponents of random length mixed in.
		for (int n = 0; n < N_RANDOM; n++) begin
			kind = $urandom_range(0, 99);
			e = EXP_W'({$urandom, $urandom});
			if (kind < 45) begin
				queue_req(MOD_W'($urandom), e, MOD_W'($urandom));
			end else if (kind < 65) begin
				queue_req(MOD_W'($urandom), EXP_W'($urandom_range(0, 64)), MOD_W'($urandom));
			end else if (kind < 82) begin
				queue_req(MOD_W'($urandom), e, MOD_W'($urandom_range(1, 16)));
			end else if (kind < 97) begin
				top = $urandom_range(1, EXP_W);
				span = (64'd1 << top) - 64'd1;
				e = EXP_W'((64'(e) & span) | (64'd1 << (top - 1)));
				queue_req(MOD_W'($urandom), e, MOD_W'($urandom));
			end else begin
				queue_req(MOD_W'($urandom), e, '0);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Poll on the falling edge, clear of the driver and monitor updates.
		while (n_accepted != n_queued || power_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d requests (%0d directed, %0d random), checked %0d results, %0d errors",
			n_accepted, n_directed, n_queued - n_directed, n_checked, n_errors);
		$display("Operands spanned zero and one-bit moduli, zero exponents and full 63-bit exponents");
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/mexp_pkg.sv
design/mexp_mulmod.sv
design/modular_exponentiation.sv
bench/modular_exponentiation_tb.sv
